### sv/abrb_pkg.sv
// ----------------------------------------------------------------------------
// abrb_pkg
// Shared types and constants of the alpha-blend region blitter: framebuffer
// geometry, command codes, register indexes and the payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abrb_pkg;

  // framebuffer geometry
  localparam int FB_COLUMNS = 128;
  localparam int FB_ROWS    = 128;
  localparam int FB_WORDS   = FB_COLUMNS * FB_ROWS;
  localparam int FB_AW      = $clog2(FB_WORDS);

  // source position wraps here whatever the image size
  localparam int POS_LIMIT = 1024;

  // configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_REGION_X     = 3'd2,
    REG_REGION_Y     = 3'd3,
    REG_REGION_W     = 3'd4,
    REG_REGION_H     = 3'd5,
    REG_DEST_X       = 3'd6,
    REG_DEST_Y       = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_SOURCE  = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  // one framebuffer word, alpha in the top byte, blue in the bottom byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    cmd_e       command;
    logic [6:0] pos_x;
    logic [6:0] pos_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_item_t;

endpackage

### sv/abrb_blend.sv
// ----------------------------------------------------------------------------
// abrb_blend
// Per-channel alpha blend of a source pixel over a framebuffer pixel:
// (s*a + d*(255-a) + 127) >> 8 on each color, stored alpha forced opaque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abrb_blend (
  input  abrb_pkg::pixel_t src_i,
  input  abrb_pkg::pixel_t dst_i,
  output abrb_pkg::pixel_t mix_o
);

  function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                     input logic [7:0] a);
    logic [16:0] acc;
    acc = 17'(s) * 17'(a) + 17'(d) * 17'(8'd255 - a) + 17'd127;
    return acc[15:8];
  endfunction

  // three independent channel lanes
  assign mix_o.blue  = mix(src_i.blue,  dst_i.blue,  src_i.alpha);
  assign mix_o.green = mix(src_i.green, dst_i.green, src_i.alpha);
  assign mix_o.red   = mix(src_i.red,   dst_i.red,   src_i.alpha);
  assign mix_o.alpha = 8'hff;

endmodule

### sv/alpha_blend_region_blitter.sv
// ----------------------------------------------------------------------------
// alpha_blend_region_blitter
// Blits a streamed source image into a 128x128 BGRA framebuffer held in one
// single-port synchronous RAM. After reset the block first clears the RAM,
// one word a cycle, during which no item is taken (configuration writes
// still are). Each item then passes through the capture and address/issue
// steps on the RAM port. A direct write, a restart, a source pixel that
// misses the region or framebuffer, or a transparent or opaque source pixel
// finishes there; a blended source pixel takes a further step for the
// read-modify-write, and a read takes a further step to load the result
// register (longer only while an earlier result still waits there). The
// RAM's single port and its registered read set these steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpha_blend_region_blitter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  abrb_pkg::in_item_t                 in_data_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output abrb_pkg::out_item_t                out_data_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [abrb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [abrb_pkg::CFG_W-1:0]         cfg_data_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_BLEND,
    ST_RESP
  } state_e;

  localparam logic signed [13:0] FBC_S = 14'(abrb_pkg::FB_COLUMNS);
  localparam logic signed [13:0] FBR_S = 14'(abrb_pkg::FB_ROWS);
  localparam logic [10:0]        POS_LIM = 11'(abrb_pkg::POS_LIMIT);
  localparam logic [abrb_pkg::FB_AW-1:0] CLR_LAST = abrb_pkg::FB_AW'(abrb_pkg::FB_WORDS - 1);

  state_e state_q, state_d;

  // configuration registers
  logic [10:0] image_width_q, image_height_q;
  logic [11:0] region_x_q, region_y_q, region_w_q, region_h_q, dest_x_q, dest_y_q;

  // stream position
  logic [9:0] col_q, col_d, row_q, row_d;

  // captured item and working registers
  abrb_pkg::in_item_t             item_q;
  logic [abrb_pkg::FB_AW-1:0]     addr_q, addr_d;
  logic [abrb_pkg::FB_AW-1:0]     clr_q, clr_d;
  logic                           resp_zero_q, resp_zero_d;
  logic                           out_valid_q, out_valid_d;
  abrb_pkg::out_item_t            out_q, out_d;

  // framebuffer ram
  logic [31:0]                    frame_mem [abrb_pkg::FB_WORDS];
  logic                           mem_we, mem_re;
  logic [abrb_pkg::FB_AW-1:0]     mem_waddr, mem_raddr;
  abrb_pkg::pixel_t               mem_wdata;
  abrb_pkg::pixel_t               rdata_q;

  abrb_pkg::pixel_t               src_pix, mix_pix;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 11'd1;
      image_height_q <= 11'd1;
      region_x_q     <= '0;
      region_y_q     <= '0;
      region_w_q     <= 12'd2048;
      region_h_q     <= 12'd2048;
      dest_x_q       <= '0;
      dest_y_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (abrb_pkg::cfg_reg_e'(cfg_idx_i))
        abrb_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[10:0];
        abrb_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[10:0];
        abrb_pkg::REG_REGION_X:     region_x_q     <= cfg_data_i;
        abrb_pkg::REG_REGION_Y:     region_y_q     <= cfg_data_i;
        abrb_pkg::REG_REGION_W:     region_w_q     <= cfg_data_i;
        abrb_pkg::REG_REGION_H:     region_h_q     <= cfg_data_i;
        abrb_pkg::REG_DEST_X:       dest_x_q       <= cfg_data_i;
        abrb_pkg::REG_DEST_Y:       dest_y_q       <= cfg_data_i;
        default:                    dest_y_q       <= dest_y_q;
      endcase
    end
  end

  // clamped region and destination position of the current source pixel
  logic signed [13:0] sx, sy, dxs, dys, sw, sh, iw, ih;
  logic signed [13:0] lox, loy, hix_raw, hiy_raw, hix, hiy, col_s, row_s, fx, fy;
  logic               region_hit, fb_hit;
  logic [abrb_pkg::FB_AW-1:0] src_addr, direct_addr;
  logic               direct_in;

  assign sx    = {{2{region_x_q[11]}}, region_x_q};
  assign sy    = {{2{region_y_q[11]}}, region_y_q};
  assign dxs   = {{2{dest_x_q[11]}}, dest_x_q};
  assign dys   = {{2{dest_y_q[11]}}, dest_y_q};
  assign sw    = {2'b00, region_w_q};
  assign sh    = {2'b00, region_h_q};
  assign iw    = {3'b000, image_width_q};
  assign ih    = {3'b000, image_height_q};
  assign col_s = {4'b0000, col_q};
  assign row_s = {4'b0000, row_q};

  assign lox     = sx[13] ? 14'sd0 : sx;
  assign loy     = sy[13] ? 14'sd0 : sy;
  assign hix_raw = sx + sw;
  assign hiy_raw = sy + sh;
  assign hix     = (hix_raw > iw) ? iw : hix_raw;
  assign hiy     = (hiy_raw > ih) ? ih : hiy_raw;

  assign region_hit = (hix > lox) && (hiy > loy) &&
                      (col_s >= lox) && (col_s < hix) &&
                      (row_s >= loy) && (row_s < hiy);

  assign fx     = dxs + col_s - sx;
  assign fy     = dys + row_s - sy;
  assign fb_hit = !fx[13] && !fy[13] && (fx < FBC_S) && (fy < FBR_S);
  assign src_addr = abrb_pkg::FB_AW'(int'(fy) * abrb_pkg::FB_COLUMNS + int'(fx));

  // direct access address
  assign direct_in   = (int'(item_q.pos_x) < abrb_pkg::FB_COLUMNS) &&
                       (int'(item_q.pos_y) < abrb_pkg::FB_ROWS);
  assign direct_addr = abrb_pkg::FB_AW'(int'(item_q.pos_y) * abrb_pkg::FB_COLUMNS +
                                        int'(item_q.pos_x));

  // position advance
  logic [10:0] next_col, next_row;
  logic        col_wrap, row_wrap;

  assign next_col = {1'b0, col_q} + 11'd1;
  assign next_row = {1'b0, row_q} + 11'd1;
  assign col_wrap = (next_col >= image_width_q) || (next_col >= POS_LIM);
  assign row_wrap = (next_row >= image_height_q) || (next_row >= POS_LIM);

  // blend unit
  assign src_pix = '{alpha: item_q.alpha, red: item_q.red,
                     green: item_q.green, blue: item_q.blue};

  abrb_blend u_blend (
    .src_i (src_pix),
    .dst_i (rdata_q),
    .mix_o (mix_pix)
  );

  // control and ram port selection
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    resp_zero_d = resp_zero_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = direct_addr;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        unique case (item_q.command)
          abrb_pkg::CMD_WRITE: begin
            mem_we    = direct_in;
            mem_waddr = direct_addr;
            mem_wdata = src_pix;
          end
          abrb_pkg::CMD_SOURCE: begin
            addr_d    = src_addr;
            mem_waddr = src_addr;
            mem_raddr = src_addr;
            if (region_hit && fb_hit) begin
              if (item_q.alpha == 8'hff) begin
                mem_we    = 1'b1;
                mem_wdata = '{alpha: 8'hff, red: item_q.red,
                              green: item_q.green, blue: item_q.blue};
              end else if (item_q.alpha != 8'd0) begin
                mem_re  = 1'b1;
                state_d = ST_BLEND;
              end
            end
            col_d = col_wrap ? 10'd0 : next_col[9:0];
            if (col_wrap) begin
              row_d = row_wrap ? 10'd0 : next_row[9:0];
            end
          end
          abrb_pkg::CMD_READ: begin
            mem_re      = direct_in;
            mem_raddr   = direct_addr;
            resp_zero_d = !direct_in;
            state_d     = ST_RESP;
          end
          abrb_pkg::CMD_RESTART: begin
            col_d = '0;
            row_d = '0;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_BLEND: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = mix_pix;
        state_d   = ST_IDLE;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (resp_zero_q) begin
            out_d = '0;
          end else begin
            out_d = '{out_red: rdata_q.red, out_green: rdata_q.green,
                      out_blue: rdata_q.blue, out_alpha: rdata_q.alpha};
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      clr_q       <= '0;
      resp_zero_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      clr_q       <= clr_d;
      resp_zero_q <= resp_zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    addr_q <= addr_d;
    out_q  <= out_d;
  end

  // framebuffer ram, one access per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= frame_mem[mem_raddr];
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // single ram port: never a read and a write together
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("framebuffer read and write in the same cycle");

  // an accepted item is evaluated in the next cycle
  a_eval_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_EVAL)
    else $error("accepted item not evaluated");

  // blending only for partial alpha
  a_blend_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BLEND |-> item_q.alpha != 8'd0 && item_q.alpha != 8'hff)
    else $error("blend entered with opaque or transparent alpha");

  // a response with room in the result register is delivered
  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RESP && (!out_valid_q || out_ready_i) |=> out_valid_q)
    else $error("read result not loaded");

endmodule

### dv/alpha_blend_region_blitter_tb.sv
// ----------------------------------------------------------------------------
// alpha_blend_region_blitter_tb
// Self-checking bench for the region blitter. A shadow framebuffer and stream
// position follow every accepted transfer and queue the expected read data;
// each read transfer on the output is compared field by field. Directed
// checks cover direct access, every alpha class, zero image sizes, empty
// regions and clipping, then long random streams run with bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpha_blend_region_blitter_tb;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 10;

  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  abrb_pkg::in_item_t             in_data  = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  abrb_pkg::out_item_t            out_data;
  logic                           cfg_we   = 1'b0;
  logic [abrb_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [abrb_pkg::CFG_W-1:0]     cfg_data = '0;

  // shadow of the block
  abrb_pkg::pixel_t    frame_model [abrb_pkg::FB_WORDS];
  logic [11:0]         cfg_shadow [8];
  int                  src_col;
  int                  src_row;
  abrb_pkg::out_item_t pending_reads [$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int stall_pct   = 0;
  int pattern_cnt = 0;

  alpha_blend_region_blitter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow framebuffer
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] mix_channel(input int s, input int d, input int a);
    return 8'((s * a + d * (255 - a) + 127) >> 8);
  endfunction

  // update the shadow for one accepted transfer
  function automatic void apply_item(input abrb_pkg::in_item_t item);
    int               idx, iw, ih, sx, sy, sw, sh, dx, dy;
    int               lox, loy, hix, hiy, fx, fy, nc, nr;
    abrb_pkg::pixel_t old;
    idx = int'(item.pos_y) * abrb_pkg::FB_COLUMNS + int'(item.pos_x);
    case (item.command)
      abrb_pkg::CMD_WRITE: begin
        frame_model[idx] = '{alpha: item.alpha, red: item.red, green: item.green,
                             blue: item.blue};
      end
      abrb_pkg::CMD_SOURCE: begin
        iw  = int'(cfg_shadow[abrb_pkg::REG_IMAGE_WIDTH][10:0]);
        ih  = int'(cfg_shadow[abrb_pkg::REG_IMAGE_HEIGHT][10:0]);
        sx  = int'($signed(cfg_shadow[abrb_pkg::REG_REGION_X]));
        sy  = int'($signed(cfg_shadow[abrb_pkg::REG_REGION_Y]));
        sw  = int'(cfg_shadow[abrb_pkg::REG_REGION_W]);
        sh  = int'(cfg_shadow[abrb_pkg::REG_REGION_H]);
        dx  = int'($signed(cfg_shadow[abrb_pkg::REG_DEST_X]));
        dy  = int'($signed(cfg_shadow[abrb_pkg::REG_DEST_Y]));
        // region clamped to the image
        lox = (sx < 0) ? 0 : sx;
        loy = (sy < 0) ? 0 : sy;
        hix = (sx + sw > iw) ? iw : sx + sw;
        hiy = (sy + sh > ih) ? ih : sy + sh;
        if (hix > lox && hiy > loy && src_col >= lox && src_col < hix &&
            src_row >= loy && src_row < hiy) begin
          fx = dx + src_col - sx;
          fy = dy + src_row - sy;
          if (fx >= 0 && fy >= 0 && fx < abrb_pkg::FB_COLUMNS &&
              fy < abrb_pkg::FB_ROWS) begin
            idx = fy * abrb_pkg::FB_COLUMNS + fx;
            old = frame_model[idx];
            if (item.alpha == 8'd255) begin
              frame_model[idx] = '{alpha: 8'd255, red: item.red, green: item.green,
                                   blue: item.blue};
            end else if (item.alpha != 8'd0) begin
              frame_model[idx] = '{alpha: 8'd255,
                red:   mix_channel(item.red,   old.red,   item.alpha),
                green: mix_channel(item.green, old.green, item.alpha),
                blue:  mix_channel(item.blue,  old.blue,  item.alpha)};
            end
          end
        end
        // raster position
        nc = src_col + 1;
        if (nc >= iw || nc >= abrb_pkg::POS_LIMIT) begin
          nr = src_row + 1;
          nc = 0;
          if (nr >= ih || nr >= abrb_pkg::POS_LIMIT) nr = 0;
          src_row = nr;
        end
        src_col = nc;
      end
      abrb_pkg::CMD_READ: begin
        old = frame_model[idx];
        pending_reads.push_back('{out_red: old.red, out_green: old.green,
                                  out_blue: old.blue, out_alpha: old.alpha});
      end
      default: begin
        src_col = 0;
        src_row = 0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic abrb_pkg::in_item_t pixel(input abrb_pkg::cmd_e cmd, input int x,
                                               input int y, input int r, input int g,
                                               input int b, input int a);
    abrb_pkg::in_item_t item;
    item.command = cmd;
    item.pos_x   = 7'(x);
    item.pos_y   = 7'(y);
    item.red     = 8'(r);
    item.green   = 8'(g);
    item.blue    = 8'(b);
    item.alpha   = 8'(a);
    return item;
  endfunction

  // random channels, alpha weighted toward opaque and transparent
  function automatic abrb_pkg::in_item_t random_pixel(input abrb_pkg::cmd_e cmd,
                                                      input int x, input int y);
    int a;
    case ($urandom_range(0, 4))
      0:       a = 0;
      1:       a = 255;
      default: a = $urandom_range(0, 255);
    endcase
    return pixel(cmd, x, y, $urandom, $urandom, $urandom, a);
  endfunction

  // one input transfer, with bursts and random gaps
  task automatic send_item(input abrb_pkg::in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    apply_item(item);
  endtask

  // write all eight registers back to back
  task automatic load_config(input int iw, input int ih, input int rx, input int ry,
                             input int rw, input int rh, input int dx, input int dy);
    int vals [8];
    vals = '{iw, ih, rx, ry, rw, rh, dx, dy};
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= abrb_pkg::cfg_reg_e'(i);
      cfg_data <= abrb_pkg::CFG_W'(vals[i]);
      cfg_shadow[i] = (i <= abrb_pkg::REG_IMAGE_HEIGHT) ? 12'(vals[i] & 'h7ff)
                                                        : 12'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // wait until the block has nothing in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // direct writes and reads at three corners and an inner pixel, and a read of an untouched pixel
  task automatic test_direct_access();
    send_item(pixel(abrb_pkg::CMD_WRITE, 0, 0, 'hff, 'h00, 'hff, 'h00));
    send_item(pixel(abrb_pkg::CMD_WRITE, 127, 127, 'h00, 'hff, 'h00, 'hff));
    send_item(pixel(abrb_pkg::CMD_WRITE, 127, 0, 'h55, 'haa, 'h55, 'haa));
    send_item(pixel(abrb_pkg::CMD_WRITE, 'h2a, 'h55, 'haa, 'h55, 'haa, 'h55));
    send_item(pixel(abrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    send_item(pixel(abrb_pkg::CMD_READ, 127, 127, 0, 0, 0, 0));
    send_item(pixel(abrb_pkg::CMD_READ, 127, 0, 0, 0, 0, 0));
    send_item(pixel(abrb_pkg::CMD_READ, 'h2a, 'h55, 0, 0, 0, 0));
    send_item(pixel(abrb_pkg::CMD_READ, 64, 64, 0, 0, 0, 0));
  endtask

  // 1x1 image at the origin: each alpha class on one pixel
  task automatic test_alpha_classes();
    settle();
    load_config(1, 1, 0, 0, 2048, 2048, 0, 0);
    send_item(pixel(abrb_pkg::CMD_WRITE, 0, 0, 'h10, 'h80, 'hf0, 'h33));
    send_item(pixel(abrb_pkg::CMD_SOURCE, 5, 9, 'hff, 'hff, 'hff, 0));
    send_item(pixel(abrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    send_item(pixel(abrb_pkg::CMD_SOURCE, 0, 0, 'hc8, 'h64, 'h32, 255));
    send_item(pixel(abrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    send_item(pixel(abrb_pkg::CMD_SOURCE, 0, 0, 'h00, 'hff, 'h7f, 128));
    send_item(pixel(abrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    send_item(pixel(abrb_pkg::CMD_SOURCE, 0, 0, 'hff, 'h00, 'h01, 1));
    send_item(pixel(abrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    send_item(pixel(abrb_pkg::CMD_SOURCE, 0, 0, 'h01, 'hfe, 'h80, 254));
    send_item(pixel(abrb_pkg::CMD_RESTART, 0, 0, 0, 0, 0, 0));
    send_item(pixel(abrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
  endtask

  // zero image sizes, empty regions and clipping at the framebuffer edges
  task automatic test_degenerate_regions();
    for (int c = 0; c < 6; c++) begin
      settle();
      case (c)
        0: load_config(0, 4, 0, 0, 2048, 2048, 0, 0);
        1: load_config(4, 0, 0, 0, 2048, 2048, 0, 0);
        2: load_config(4, 4, -2048, 2047, 2048, 2048, 0, 0);
        3: load_config(4, 4, 0, 0, 4, 4, 2047, -2048);
        4: load_config(4, 4, 0, 0, 0, 4, 0, 0);
        default: load_config(4, 1, 0, 0, 2048, 2048, -1, 0);
      endcase
      send_item(pixel(abrb_pkg::CMD_RESTART, 0, 0, 0, 0, 0, 0));
      repeat (3) send_item(random_pixel(abrb_pkg::CMD_SOURCE, $urandom, $urandom));
      send_item(pixel(abrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
      send_item(pixel(abrb_pkg::CMD_READ, 1, 0, 0, 0, 0, 0));
    end
  endtask

  // full-width rows: the column wraps at the position limit
  task automatic test_wide_image();
    settle();
    load_config($urandom_range(0, 1) ? 1024 : 2047, 2, 1000, 0, 2048, 2, 100, 0);
    send_item(pixel(abrb_pkg::CMD_RESTART, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < abrb_pkg::POS_LIMIT + 30; i++) begin
      send_item(random_pixel(abrb_pkg::CMD_SOURCE, $urandom, $urandom));
      if ($urandom_range(0, 15) == 0)
        send_item(pixel(abrb_pkg::CMD_READ, 100 + $urandom_range(0, 27),
                        $urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  // small random blits with direct access and restarts mixed in
  task automatic test_random_blits();
    int sent, iw, ih, rx, ry, rw, rh, dx, dy, r;
    sent = 0;
    while (sent < 150) begin
      settle();
      iw = $urandom_range(1, 12);
      ih = $urandom_range(1, 10);
      rx = $urandom_range(0, 15) - 3;
      ry = $urandom_range(0, 13) - 3;
      rw = $urandom_range(0, 14);
      rh = $urandom_range(0, 12);
      dx = $urandom_range(0, 137) - 6;
      dy = $urandom_range(0, 137) - 6;
      // now and then a register at an extreme
      case ($urandom_range(0, 9))
        0: rx = -2048;
        1: ry = 2047;
        2: rw = 2048;
        3: rh = 2048;
        4: dx = 2047;
        5: dy = -2048;
        default: ;
      endcase
      load_config(iw, ih, rx, ry, rw, rh, dx, dy);
      send_item(pixel(abrb_pkg::CMD_RESTART, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < iw * ih + $urandom_range(0, 4); i++) begin
        send_item(random_pixel(abrb_pkg::CMD_SOURCE, $urandom, $urandom));
        sent++;
        r = $urandom_range(0, 99);
        if (r < 15)
          send_item(pixel(abrb_pkg::CMD_READ, (dx + $urandom_range(0, 12)) & 127,
                          (dy + $urandom_range(0, 10)) & 127, 0, 0, 0, 0));
        else if (r < 20)
          send_item(random_pixel(abrb_pkg::CMD_WRITE, (dx + $urandom_range(0, 12)) & 127,
                                 (dy + $urandom_range(0, 10)) & 127));
        else if (r < 25)
          send_item(random_pixel(abrb_pkg::CMD_READ, $urandom, $urandom));
        else if (r < 27)
          send_item(random_pixel(abrb_pkg::CMD_RESTART, $urandom, $urandom));
      end
      repeat (4)
        send_item(pixel(abrb_pkg::CMD_READ, (dx + $urandom_range(0, 12)) & 127,
                        (dy + $urandom_range(0, 10)) & 127, 0, 0, 0, 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) note_mismatch($sformatf("%s expected %02h got %02h", name, want, got));
  endtask

  // compare each read transfer with the oldest expected pixel
  always @(posedge clk) begin
    abrb_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        note_mismatch($sformatf("read data %08h with no read pending", out_data));
      end else begin
        want = pending_reads.pop_front();
        check_channel("red",   want.out_red,   out_data.out_red);
        check_channel("green", want.out_green, out_data.out_green);
        check_channel("blue",  want.out_blue,  out_data.out_blue);
        check_channel("alpha", want.out_alpha, out_data.out_alpha);
      end
    end
  end

  // receiver stall pattern, with a stall rate redrawn from 0, 25, 60 or 90 percent
  always @(posedge clk) begin
    pattern_cnt <= pattern_cnt + 1;
    if (pattern_cnt % 128 == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct <= 0;
        1:       stall_pct <= 25;
        2:       stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < abrb_pkg::FB_WORDS; i++) frame_model[i] = '0;
    src_col = 0;
    src_row = 0;
    cfg_shadow = '{12'd1, 12'd1, 12'd0, 12'd0, 12'd2048, 12'd2048, 12'd0, 12'd0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_direct_access();
    test_alpha_classes();
    test_degenerate_regions();
    test_wide_image();
    test_random_blits();

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
